FILE: rtl/assert_macros.svh
// assertion macros used by the rtl top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define AST_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: rtl/c8i_pkg.sv
// chip-8 core package: action codes, opcode constants, fixed sizes and font glyphs
// no dependencies
package c8i_pkg;
    localparam int MEM_BYTES     = 4096;
    localparam int ADDR_W        = 12;
    localparam int SCREEN_HEIGHT = 32;
    localparam int FONT_LEN      = 80;

    typedef enum logic [2:0] {
        ACT_EXEC  = 3'd0,
        ACT_TICK  = 3'd1,
        ACT_KDOWN = 3'd2,
        ACT_KUP   = 3'd3,
        ACT_LOAD  = 3'd4,
        ACT_ROW   = 3'd5,
        ACT_SRST  = 3'd6,
        ACT_NOP   = 3'd7
    } t_action;

    localparam logic [7:0] C8I_FONT [FONT_LEN] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    localparam logic [11:0] OP_CLS = 12'h0E0;
    localparam logic [11:0] OP_RET = 12'h0EE;
    localparam logic [7:0]  OP_SKP  = 8'h9E;
    localparam logic [7:0]  OP_SKNP = 8'hA1;
    localparam logic [7:0]  OP_LDDT = 8'h07;
    localparam logic [7:0]  OP_WKEY = 8'h0A;
    localparam logic [7:0]  OP_SDT  = 8'h15;
    localparam logic [7:0]  OP_SST  = 8'h18;
    localparam logic [7:0]  OP_ADDI = 8'h1E;
    localparam logic [7:0]  OP_FONT = 8'h29;
    localparam logic [7:0]  OP_BCD  = 8'h33;
    localparam logic [7:0]  OP_STR  = 8'h55;
    localparam logic [7:0]  OP_LDR  = 8'h65;
endpackage

FILE: rtl/chip8_instruction_core_top.sv
// chip-8 instruction core top level: sequencer, registers, screen and timers
// depends on c8i_pkg, c8i_mem and assert_macros.svh
//
// usage:
//   a transaction is accepted when start is high and busy is low; the inputs
//   are sampled at that edge. exactly one result follows, shown for one cycle
//   with o_done high; the receiver cannot stall it and it is never held.
//   states per transaction, from the accepting edge to the o_done cycle:
//     timer tick, key, read row, unused action: straight to S_DONE
//     load byte: S_LOADW, then S_DONE
//     execute: S_FHI, S_FLO, S_DEC, S_RX, S_RY, S_EXEC, then S_DONE;
//     sprite draw adds S_DRA and S_DRB per row plus a final S_DRA, Fx65
//     adds S_L65A and S_L65B per register, Fx55 adds S_S55 per register,
//     Fx33 adds S_B0, S_B1 and S_B2; soft reset: the memory clearing pass
//   the memory has one write port, so the clearing pass writes one byte a
//   cycle over all 4096 bytes, refilling the font at FONT_BASE.
//   after i_rst_n the same pass runs with busy high and no result.
//   one transaction is in flight at a time; busy stays high through the
//   o_done cycle and the next transaction can be accepted in the cycle after it.
`include "assert_macros.svh"

module chip8_instruction_core_top #(
    parameter int PROGRAM_START = 512,
    parameter int FONT_BASE     = 80,
    parameter int STACK_DEPTH   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    output logic        o_done,
    input  logic [2:0]  i_action,
    input  logic [3:0]  i_key_index,
    input  logic [11:0] i_load_address,
    input  logic [7:0]  i_load_byte,
    input  logic [7:0]  i_random_byte,
    input  logic [4:0]  i_row_select,
    output logic [11:0] o_program_address,
    output logic [15:0] o_index_value,
    output logic        o_sound_on,
    output logic        o_waiting_key,
    output logic        o_bad_opcode,
    output logic [63:0] o_row_pixels
);
    import c8i_pkg::*;

    localparam int SPW = $clog2(STACK_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE, S_CLR, S_LOADW, S_FHI, S_FLO, S_DEC, S_RX, S_RY, S_EXEC,
        S_DRA, S_DRB, S_B0, S_B1, S_B2, S_S55, S_L65A, S_L65B, S_DONE
    } t_state;

    t_state r_state;
    logic        r_soft;
    logic [11:0] r_clr;
    logic [11:0] r_pc;
    logic [15:0] r_i;
    logic [7:0]  r_v [16];
    logic [11:0] r_stack [STACK_DEPTH];
    logic [SPW-1:0] r_sp;
    logic [7:0]  r_dt, r_st;
    logic [15:0] r_keys;
    logic [63:0] r_fb [SCREEN_HEIGHT];
    logic [15:0] r_op;
    logic [7:0]  r_vx, r_vy;
    logic [4:0]  r_cnt;
    logic [11:0] r_laddr;
    logic [7:0]  r_lbyte, r_rnd;
    logic        r_wait, r_bad;
    logic [63:0] r_row;

    logic        mem_we;
    logic [11:0] mem_waddr, mem_raddr;
    logic [7:0]  mem_wdata, mem_rdata;

    c8i_mem u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    logic [3:0]  op_x, op_y, op_n;
    logic [7:0]  op_nn;
    logic [11:0] op_nnn;
    logic [11:0] i_plus;
    logic [11:0] font_idx;
    logic [7:0]  clr_byte;
    logic [3:0]  v_sel;
    logic [7:0]  v_rd;
    logic [7:0]  add_a, add_b;
    logic        add_ci;
    logic [8:0]  add_sum;
    logic [SPW-1:0] sp_inc, sp_dec;
    logic        key_found;
    logic [3:0]  key_first;
    logic [1:0]  bcd_h;
    logic [7:0]  bcd_rem;
    logic [15:0] bcd_prod;
    logic [3:0]  bcd_t;
    logic [7:0]  bcd_o;
    logic [127:0] spr_wide;
    logic [63:0] spr_mask;
    logic [4:0]  spr_line;

    assign op_x   = r_op[11:8];
    assign op_y   = r_op[7:4];
    assign op_n   = r_op[3:0];
    assign op_nn  = r_op[7:0];
    assign op_nnn = r_op[11:0];
    assign i_plus = r_i[11:0] + {7'd0, r_cnt};

    assign font_idx = r_clr - 12'(FONT_BASE);
    assign clr_byte = (font_idx < 12'(FONT_LEN)) ? C8I_FONT[font_idx[6:0]] : 8'd0;

    always_comb begin
        case (r_state)
            S_RX:    v_sel = op_x;
            S_RY:    v_sel = op_y;
            default: v_sel = r_cnt[3:0];
        endcase
    end
    assign v_rd = r_v[v_sel];

    // shared alu adder
    always_comb begin
        add_a  = r_vx;
        add_b  = op_nn;
        add_ci = 1'b0;
        if (r_op[15:12] == 4'h8) begin
            case (op_n)
                4'h5: begin
                    add_b  = ~r_vy;
                    add_ci = 1'b1;
                end
                4'h7: begin
                    add_a  = r_vy;
                    add_b  = ~r_vx;
                    add_ci = 1'b1;
                end
                default: add_b = r_vy;
            endcase
        end
    end
    assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {8'd0, add_ci};

    assign sp_inc = (r_sp == SPW'(STACK_DEPTH - 1)) ? '0 : r_sp + 1'b1;
    assign sp_dec = (r_sp == '0) ? SPW'(STACK_DEPTH - 1) : r_sp - 1'b1;

    always_comb begin
        key_found = 1'b0;
        key_first = 4'd0;
        for (int k = 15; k >= 0; k--) begin
            if (r_keys[k]) begin
                key_found = 1'b1;
                key_first = 4'(k);
            end
        end
    end

    // decimal digits by compare and reciprocal multiply
    always_comb begin
        if (r_vx >= 8'd200) begin
            bcd_h   = 2'd2;
            bcd_rem = r_vx - 8'd200;
        end else if (r_vx >= 8'd100) begin
            bcd_h   = 2'd1;
            bcd_rem = r_vx - 8'd100;
        end else begin
            bcd_h   = 2'd0;
            bcd_rem = r_vx;
        end
    end
    assign bcd_prod = {8'd0, bcd_rem} * 16'd205;
    assign bcd_t    = bcd_prod[14:11];
    assign bcd_o    = bcd_rem - {bcd_t, 3'd0} - {3'd0, bcd_t, 1'b0};

    // sprite byte rotated into screen columns
    assign spr_wide = {mem_rdata, 56'd0, mem_rdata, 56'd0} >> r_vx[5:0];
    assign spr_mask = spr_wide[63:0];
    assign spr_line = r_vy[4:0] + r_cnt;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = i_plus;
        mem_wdata = 8'd0;
        mem_raddr = i_plus;
        case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = clr_byte;
            end
            S_LOADW: begin
                mem_we    = 1'b1;
                mem_waddr = r_laddr;
                mem_wdata = r_lbyte;
            end
            S_B0: begin
                mem_we    = 1'b1;
                mem_waddr = r_i[11:0];
                mem_wdata = {6'd0, bcd_h};
            end
            S_B1: begin
                mem_we    = 1'b1;
                mem_waddr = r_i[11:0] + 12'd1;
                mem_wdata = {4'd0, bcd_t};
            end
            S_B2: begin
                mem_we    = 1'b1;
                mem_waddr = r_i[11:0] + 12'd2;
                mem_wdata = bcd_o;
            end
            S_S55: begin
                mem_we    = 1'b1;
                mem_wdata = v_rd;
            end
            S_FHI:   mem_raddr = r_pc;
            S_FLO:   mem_raddr = r_pc + 12'd1;
            default: mem_raddr = i_plus;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_soft  <= 1'b0;
            r_clr   <= '0;
            r_pc    <= 12'(PROGRAM_START);
            r_i     <= 16'(FONT_BASE);
            r_sp    <= '0;
            r_dt    <= '0;
            r_st    <= '0;
            r_keys  <= '0;
            r_wait  <= 1'b0;
            r_bad   <= 1'b0;
            r_row   <= '0;
            r_cnt   <= '0;
            for (int k = 0; k < 16; k++) r_v[k] <= '0;
            for (int k = 0; k < STACK_DEPTH; k++) r_stack[k] <= '0;
            for (int k = 0; k < SCREEN_HEIGHT; k++) r_fb[k] <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_wait  <= 1'b0;
                        r_bad   <= 1'b0;
                        r_row   <= '0;
                        r_laddr <= i_load_address;
                        r_lbyte <= i_load_byte;
                        r_rnd   <= i_random_byte;
                        r_state <= S_DONE;
                        case (t_action'(i_action))
                            ACT_EXEC: r_state <= S_FHI;
                            ACT_TICK: begin
                                if (r_dt != 8'd0) r_dt <= r_dt - 8'd1;
                                if (r_st != 8'd0) r_st <= r_st - 8'd1;
                            end
                            ACT_KDOWN: r_keys[i_key_index] <= 1'b1;
                            ACT_KUP:   r_keys[i_key_index] <= 1'b0;
                            ACT_LOAD:  r_state <= S_LOADW;
                            ACT_ROW:   r_row <= r_fb[i_row_select];
                            ACT_SRST: begin
                                r_state <= S_CLR;
                                r_soft  <= 1'b1;
                                r_clr   <= '0;
                                r_pc    <= 12'(PROGRAM_START);
                                r_i     <= 16'(FONT_BASE);
                                r_sp    <= '0;
                                r_dt    <= '0;
                                r_st    <= '0;
                                r_keys  <= '0;
                                for (int k = 0; k < 16; k++) r_v[k] <= '0;
                                for (int k = 0; k < STACK_DEPTH; k++) r_stack[k] <= '0;
                                for (int k = 0; k < SCREEN_HEIGHT; k++) r_fb[k] <= '0;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_CLR: begin
                    r_clr <= r_clr + 12'd1;
                    if (r_clr == 12'(MEM_BYTES - 1)) begin
                        r_state <= r_soft ? S_DONE : S_IDLE;
                        r_soft  <= 1'b0;
                    end
                end
                S_LOADW: r_state <= S_DONE;
                S_FHI:   r_state <= S_FLO;
                S_FLO: begin
                    r_op[15:8] <= mem_rdata;
                    r_state    <= S_DEC;
                end
                S_DEC: begin
                    r_op[7:0] <= mem_rdata;
                    r_pc      <= r_pc + 12'd2;
                    r_state   <= S_RX;
                end
                S_RX: begin
                    r_vx    <= v_rd;
                    r_state <= S_RY;
                end
                S_RY: begin
                    r_vy    <= v_rd;
                    r_cnt   <= '0;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_state <= S_DONE;
                    case (r_op[15:12])
                        4'h0: begin
                            if (op_nnn == OP_CLS) begin
                                for (int k = 0; k < SCREEN_HEIGHT; k++) r_fb[k] <= '0;
                            end else if (op_nnn == OP_RET) begin
                                r_sp <= sp_dec;
                                r_pc <= r_stack[sp_dec];
                            end else begin
                                r_bad <= 1'b1;
                            end
                        end
                        4'h1: r_pc <= op_nnn;
                        4'h2: begin
                            r_stack[r_sp] <= r_pc;
                            r_sp          <= sp_inc;
                            r_pc          <= op_nnn;
                        end
                        4'h3: if (r_vx == op_nn) r_pc <= r_pc + 12'd2;
                        4'h4: if (r_vx != op_nn) r_pc <= r_pc + 12'd2;
                        4'h5: if (r_vx == r_vy) r_pc <= r_pc + 12'd2;
                        4'h6: r_v[op_x] <= op_nn;
                        4'h7: r_v[op_x] <= add_sum[7:0];
                        4'h8: begin
                            case (op_n)
                                4'h0: r_v[op_x] <= r_vy;
                                4'h1: r_v[op_x] <= r_vx | r_vy;
                                4'h2: r_v[op_x] <= r_vx & r_vy;
                                4'h3: r_v[op_x] <= r_vx ^ r_vy;
                                4'h4, 4'h5, 4'h7: begin
                                    r_v[op_x] <= add_sum[7:0];
                                    r_v[15]   <= {7'd0, add_sum[8]};
                                end
                                4'h6: begin
                                    r_v[op_x] <= {1'b0, r_vx[7:1]};
                                    r_v[15]   <= {7'd0, r_vx[0]};
                                end
                                4'hE: begin
                                    r_v[op_x] <= {r_vx[6:0], 1'b0};
                                    r_v[15]   <= {7'd0, r_vx[7]};
                                end
                                default: r_bad <= 1'b1;
                            endcase
                        end
                        4'h9: if (r_vx != r_vy) r_pc <= r_pc + 12'd2;
                        4'hA: r_i <= {4'd0, op_nnn};
                        4'hC: r_v[op_x] <= r_rnd & op_nn;
                        4'hD: begin
                            r_v[15] <= 8'd0;
                            r_state <= S_DRA;
                        end
                        4'hE: begin
                            if (op_nn == OP_SKP) begin
                                if (r_keys[r_vx[3:0]]) r_pc <= r_pc + 12'd2;
                            end else if (op_nn == OP_SKNP) begin
                                if (!r_keys[r_vx[3:0]]) r_pc <= r_pc + 12'd2;
                            end else begin
                                r_bad <= 1'b1;
                            end
                        end
                        4'hF: begin
                            case (op_nn)
                                OP_LDDT: r_v[op_x] <= r_dt;
                                OP_WKEY: begin
                                    if (key_found) begin
                                        r_v[op_x] <= {4'd0, key_first};
                                    end else begin
                                        r_pc   <= r_pc - 12'd2;
                                        r_wait <= 1'b1;
                                    end
                                end
                                OP_SDT:  r_dt <= r_vx;
                                OP_SST:  r_st <= r_vx;
                                OP_ADDI: r_i <= r_i + {8'd0, r_vx};
                                OP_FONT: r_i <= 16'(FONT_BASE) + {6'd0, r_vx, 2'd0}
                                                + {8'd0, r_vx};
                                OP_BCD:  r_state <= S_B0;
                                OP_STR:  r_state <= S_S55;
                                OP_LDR:  r_state <= S_L65A;
                                default: r_bad <= 1'b1;
                            endcase
                        end
                        default: r_bad <= 1'b1;
                    endcase
                end
                S_DRA: r_state <= (r_cnt[3:0] == op_n && !r_cnt[4]) ? S_DONE : S_DRB;
                S_DRB: begin
                    if ((r_fb[spr_line] & spr_mask) != 64'd0) r_v[15] <= 8'd1;
                    r_fb[spr_line] <= r_fb[spr_line] ^ spr_mask;
                    r_cnt   <= r_cnt + 5'd1;
                    r_state <= S_DRA;
                end
                S_B0: r_state <= S_B1;
                S_B1: r_state <= S_B2;
                S_B2: r_state <= S_DONE;
                S_S55: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt[3:0] == op_x) r_state <= S_DONE;
                end
                S_L65A: r_state <= S_L65B;
                S_L65B: begin
                    r_v[r_cnt[3:0]] <= mem_rdata;
                    r_cnt           <= r_cnt + 5'd1;
                    r_state         <= (r_cnt[3:0] == op_x) ? S_DONE : S_L65A;
                end
                S_DONE:  r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy              = (r_state != S_IDLE);
    assign o_done            = (r_state == S_DONE);
    assign o_program_address = r_pc;
    assign o_index_value     = r_i;
    assign o_sound_on        = (r_st != 8'd0);
    assign o_waiting_key     = r_wait;
    assign o_bad_opcode      = r_bad;
    assign o_row_pixels      = r_row;

    `AST_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)
    `AST_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    `AST_SAME(a_done_busy, i_clk, i_rst_n, o_done, busy)
    `AST_SAME(a_flags_excl, i_clk, i_rst_n, o_done, !(o_waiting_key && o_bad_opcode))
endmodule

FILE: rtl/c8i_mem.sv
// chip-8 main memory: one write port, one registered read port
// depends on c8i_pkg
module c8i_mem (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [c8i_pkg::ADDR_W-1:0] i_waddr,
    input  logic [7:0]                i_wdata,
    input  logic [c8i_pkg::ADDR_W-1:0] i_raddr,
    output logic [7:0]                o_rdata
);
    import c8i_pkg::*;

    logic [7:0] r_mem [MEM_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
